// File: hw/rtl/top_k_repeat_read_tracker_defines.svh
// Assertion macros shared by the top-k repeat-read tracker modules.
`ifndef TOP_K_REPEAT_READ_TRACKER_DEFINES_SVH
`define TOP_K_REPEAT_READ_TRACKER_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define TKRR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that must hold in every cycle, reset included.
`define TKRR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/tkrr_pkg.sv
// Types and constants of the top-k repeat-read tracker.
package tkrr_pkg;

  localparam int unsigned RankW         = 3;
  localparam int unsigned CountW        = 32;
  localparam int unsigned DeviceW       = 32;
  localparam int unsigned SectorW       = 64;
  localparam logic [31:0] MinCountReset = 32'd2;

  typedef enum logic {
    FUNC_OFFER = 1'b0,
    FUNC_EOW   = 1'b1
  } func_e;

  typedef struct packed {
    func_e                func;
    logic [DeviceW-1:0]   device_id;
    logic [SectorW-1:0]   sector_number;
    logic [CountW-1:0]    repeat_count;
  } in_item_t;

  typedef struct packed {
    logic [RankW-1:0]     rank;
    logic [DeviceW-1:0]   out_device;
    logic [SectorW-1:0]   out_sector;
    logic [CountW-1:0]    out_count;
    logic                 last_entry;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_REPORT = 2'b10
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic offer;
    logic start;
    logic pop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_zero;
    logic fill_one;
  } sts_t;

endpackage

// File: hw/rtl/tkrr_dp.sv
// Datapath: sorted entry list, threshold register, report shifter and output register.
`include "top_k_repeat_read_tracker_defines.svh"

module tkrr_dp import tkrr_pkg::*; #(
  parameter int unsigned TOP_K = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  in_item_t            in_data_i,
  input  logic                cfg_valid_i,
  input  logic [CountW-1:0]   cfg_data_i,
  output out_item_t           out_data_o
);

  localparam int unsigned FillW = $clog2(TOP_K + 1);

  logic [CountW-1:0]  min_q;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [RankW-1:0]   rank_q, rank_d;
  out_item_t          out_q;

  logic [DeviceW-1:0] dev_q [TOP_K];
  logic [SectorW-1:0] sec_q [TOP_K];
  logic [CountW-1:0]  cnt_q [TOP_K];
  logic [DeviceW-1:0] dev_d [TOP_K];
  logic [SectorW-1:0] sec_d [TOP_K];
  logic [CountW-1:0]  cnt_d [TOP_K];

  logic [TOP_K-1:0]   vld;
  logic [TOP_K-1:0]   ge;
  logic [TOP_K-1:0]   take_new;
  logic               list_full;
  logic               insert;

  assign list_full = (fill_q == FillW'(TOP_K));
  // When full, the offer has to beat the lowest held count strictly.
  assign insert = cmd_i.offer && (in_data_i.repeat_count >= min_q) &&
                  (!list_full || (in_data_i.repeat_count > cnt_q[TOP_K-1]));

  for (genvar g = 0; g < TOP_K; g++) begin : g_entry
    logic [DeviceW-1:0] up_dev, dn_dev;
    logic [SectorW-1:0] up_sec, dn_sec;
    logic [CountW-1:0]  up_cnt, dn_cnt;

    assign vld[g] = (FillW'(g) < fill_q);
    assign ge[g]  = vld[g] && (cnt_q[g] >= in_data_i.repeat_count);

    if (g == 0) begin : g_head
      assign take_new[g] = 1'b1;
      assign up_dev = in_data_i.device_id;
      assign up_sec = in_data_i.sector_number;
      assign up_cnt = in_data_i.repeat_count;
    end else begin : g_body
      // Equal counts stay ahead of the new entry, which keeps arrival order.
      assign take_new[g] = ge[g-1];
      assign up_dev = dev_q[g-1];
      assign up_sec = sec_q[g-1];
      assign up_cnt = cnt_q[g-1];
    end

    if (g == TOP_K - 1) begin : g_tail
      assign dn_dev = dev_q[g];
      assign dn_sec = sec_q[g];
      assign dn_cnt = cnt_q[g];
    end else begin : g_inner
      assign dn_dev = dev_q[g+1];
      assign dn_sec = sec_q[g+1];
      assign dn_cnt = cnt_q[g+1];
    end

    always_comb begin
      dev_d[g] = dev_q[g];
      sec_d[g] = sec_q[g];
      cnt_d[g] = cnt_q[g];
      priority if (insert && !ge[g]) begin
        if (take_new[g]) begin
          dev_d[g] = in_data_i.device_id;
          sec_d[g] = in_data_i.sector_number;
          cnt_d[g] = in_data_i.repeat_count;
        end else begin
          dev_d[g] = up_dev;
          sec_d[g] = up_sec;
          cnt_d[g] = up_cnt;
        end
      end else if (cmd_i.pop) begin
        dev_d[g] = dn_dev;
        sec_d[g] = dn_sec;
        cnt_d[g] = dn_cnt;
      end else begin
        dev_d[g] = dev_q[g];
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    priority if (insert && !list_full) begin
      fill_d = fill_q + FillW'(1);
    end else if (cmd_i.pop) begin
      fill_d = fill_q - FillW'(1);
    end else begin
      fill_d = fill_q;
    end
  end

  always_comb begin
    rank_d = rank_q;
    priority if (cmd_i.start) begin
      rank_d = '0;
    end else if (cmd_i.pop) begin
      rank_d = rank_q + RankW'(1);
    end else begin
      rank_d = rank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= MinCountReset;
      fill_q <= '0;
      rank_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        min_q <= cfg_data_i;
      end
      fill_q <= fill_d;
      rank_q <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TOP_K; i++) begin
      dev_q[i] <= dev_d[i];
      sec_q[i] <= sec_d[i];
      cnt_q[i] <= cnt_d[i];
    end
    if (cmd_i.pop) begin
      out_q.rank       <= rank_q;
      out_q.out_device <= dev_q[0];
      out_q.out_sector <= sec_q[0];
      out_q.out_count  <= cnt_q[0];
      out_q.last_entry <= (fill_q == FillW'(1));
    end
  end

  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.fill_one  = (fill_q == FillW'(1));
  assign out_data_o      = out_q;

  `TKRR_ASSERT(a_fill_bound, fill_q <= FillW'(TOP_K), "fill level exceeds list size")
  `TKRR_ASSERT(a_pop_dec, cmd_i.pop |=> fill_q == $past(fill_q) - FillW'(1),
               "report transfer did not retire one entry")
  `TKRR_ASSERT(a_start_rank, cmd_i.start |=> rank_q == '0, "report did not restart at rank zero")

endmodule

// File: hw/rtl/tkrr_ctrl.sv
// Controller: input acceptance, report sequencing and output valid.
`include "top_k_repeat_read_tracker_defines.svh"

module tkrr_ctrl import tkrr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  func_e  in_func_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  input  sts_t   sts_i,
  output cmd_t   cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign cmd_o.offer = in_xfer && (in_func_i == FUNC_OFFER);
  assign cmd_o.start = in_xfer && (in_func_i == FUNC_EOW);
  // The output register is free when empty or when its result leaves this cycle.
  assign cmd_o.pop   = (state_q == ST_REPORT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.start && !sts_i.fill_zero) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (cmd_o.pop && sts_i.fill_one) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.pop) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `TKRR_ASSERT_ALWAYS(a_no_offer_pop, !(cmd_o.pop && cmd_o.offer),
                      "offer and report transfer in the same cycle")
  `TKRR_ASSERT(a_report_nonempty, state_q == ST_REPORT |-> !sts_i.fill_zero,
               "report running on an empty list")
  `TKRR_ASSERT(a_report_end, cmd_o.pop && sts_i.fill_one |=> state_q == ST_IDLE,
               "report did not end after its last entry")
  `TKRR_ASSERT(a_report_entry,
               state_q == ST_REPORT && $past(state_q == ST_IDLE) |-> $past(cmd_o.start),
               "report began without an end-of-window transfer")

endmodule

// File: hw/rtl/top_k_repeat_read_tracker.sv
// Top level of the top-k repeat-read tracker.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  in_data_i (in_item_t)
//   out      output     out_valid_o/out_stall_i out_data_o (out_item_t)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (min_repeat_count)
//
// Offers can follow each other in every cycle while no report is running, since all held
// entries are compared against the new count in parallel.
// An end-of-window transfer holds input off while its n held entries are shifted out of the
// list, one entry per cycle while the output is not stalled.
// Reset empties the list and sets min_repeat_count to 2; no clearing pass is needed.
// Results wait in an output register, so input is taken again while the last one is stalled.
module top_k_repeat_read_tracker import tkrr_pkg::*; #(
  parameter int unsigned TOP_K = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  tkrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_func_i   (in_data_i.func),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tkrr_dp #(
    .TOP_K (TOP_K)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule
